>>> design/ioc_pkg.sv
package ioc_pkg;

    localparam int AXES      = 6;
    localparam int ACC_AXES  = 3;
    localparam int W_RAW     = 16;
    localparam int W_DEV     = 17;
    localparam int W_SUM     = 26;
    localparam int W_CNT     = 10;
    localparam int W_FILT    = 18;
    localparam int W_FSUM    = 20;
    localparam int W_NOISE   = 16;
    localparam int W_SEL     = 3;
    localparam int DIV_STEPS = W_SUM;
    localparam int W_DIVC    = $clog2(DIV_STEPS);

    localparam logic [W_CNT-1:0] CALIB_RESET = 10'd100;

    typedef enum logic [1:0] {
        PH_SUM   = 2'd0,
        PH_NOISE = 2'd1,
        PH_RUN   = 2'd2
    } t_phase;

    // controller -> datapath
    typedef struct packed {
        logic             capture;   // load input buffer
        logic             proc;      // process buffered sample
        logic             restart;   // clear sums and peaks
        logic             accum;     // add sample to sums
        logic             track;     // update noise peaks
        logic             div_load;  // start offset divide
        logic             div_step;  // one quotient bit per lane
        logic             div_done;  // write offsets
        t_phase           ph;        // phase reported with this sample
        logic [W_CNT-1:0] div_n;     // divisor (effective sample count)
    } t_ctrl_cmd;

endpackage

>>> design/ioc_in_if.sv
interface ioc_in_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic signed [ioc_pkg::W_RAW-1:0]  acc_x_raw;
    logic signed [ioc_pkg::W_RAW-1:0]  acc_y_raw;
    logic signed [ioc_pkg::W_RAW-1:0]  acc_z_raw;
    logic signed [ioc_pkg::W_RAW-1:0]  gyro_x_raw;
    logic signed [ioc_pkg::W_RAW-1:0]  gyro_y_raw;
    logic signed [ioc_pkg::W_RAW-1:0]  gyro_z_raw;
    logic [ioc_pkg::W_SEL-1:0]         noise_axis;

    modport source (
        output valid, opcode, acc_x_raw, acc_y_raw, acc_z_raw,
               gyro_x_raw, gyro_y_raw, gyro_z_raw, noise_axis,
        input  ready
    );
    modport sink (
        input  valid, opcode, acc_x_raw, acc_y_raw, acc_z_raw,
               gyro_x_raw, gyro_y_raw, gyro_z_raw, noise_axis,
        output ready
    );
endinterface

interface ioc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ioc_pkg::W_DEV-1:0]  acc_x_filt;
    logic signed [ioc_pkg::W_DEV-1:0]  acc_y_filt;
    logic signed [ioc_pkg::W_DEV-1:0]  acc_z_filt;
    logic signed [ioc_pkg::W_DEV-1:0]  gyro_x_corr;
    logic signed [ioc_pkg::W_DEV-1:0]  gyro_y_corr;
    logic signed [ioc_pkg::W_DEV-1:0]  gyro_z_corr;
    logic [1:0]                        phase;
    logic [ioc_pkg::W_NOISE-1:0]       noise_peak;

    modport source (
        output valid, acc_x_filt, acc_y_filt, acc_z_filt,
               gyro_x_corr, gyro_y_corr, gyro_z_corr, phase, noise_peak,
        input  ready
    );
    modport sink (
        input  valid, acc_x_filt, acc_y_filt, acc_z_filt,
               gyro_x_corr, gyro_y_corr, gyro_z_corr, phase, noise_peak,
        output ready
    );
endinterface

>>> design/ioc_ctrl.sv
module ioc_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_cfg_we,
    input  logic [ioc_pkg::W_CNT-1:0]       i_cfg_wdata,
    input  logic                            i_opcode,
    output ioc_pkg::t_ctrl_cmd              o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_FIN  = 2'd2
    } t_state;

    t_state                          r_state, n_state;
    ioc_pkg::t_phase                 r_phase, n_phase;
    logic [ioc_pkg::W_CNT-1:0]       r_count, n_count;
    logic [ioc_pkg::W_CNT-1:0]       r_calib, n_calib;
    logic [ioc_pkg::W_DIVC-1:0]      r_div_cnt, n_div_cnt;
    logic                            r_in_full, n_in_full;
    logic                            r_out_valid, n_out_valid;

    logic                            accept;
    logic                            out_free;
    logic [ioc_pkg::W_CNT-1:0]       n_eff;
    logic [ioc_pkg::W_CNT-1:0]       cnt_base;
    logic [ioc_pkg::W_CNT-1:0]       cnt_inc;
    logic                            phase_end;
    ioc_pkg::t_phase                 ph;

    assign o_in_ready  = !r_in_full;
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && !r_in_full;
    assign out_free    = !r_out_valid || i_out_ready;
    // a count of zero behaves as one
    assign n_eff       = (r_calib == '0) ? ioc_pkg::W_CNT'(1) : r_calib;

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = accept;
        o_cmd.div_n   = n_eff;

        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_div_cnt   = r_div_cnt;
        n_calib     = i_cfg_we ? i_cfg_wdata : r_calib;
        n_in_full   = r_in_full;
        n_out_valid = r_out_valid && !i_out_ready;

        ph        = i_opcode ? ioc_pkg::PH_SUM : r_phase;
        cnt_base  = i_opcode ? '0 : r_count;
        cnt_inc   = cnt_base + ioc_pkg::W_CNT'(1);
        phase_end = (cnt_inc >= n_eff);

        if (accept) begin
            n_in_full = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (r_in_full && out_free) begin
                    o_cmd.proc    = 1'b1;
                    o_cmd.restart = i_opcode;
                    o_cmd.ph      = ph;
                    n_in_full     = 1'b0;
                    n_out_valid   = 1'b1;
                    n_phase       = ph;
                    case (ph)
                        ioc_pkg::PH_SUM: begin
                            o_cmd.accum = 1'b1;
                            if (phase_end) begin
                                o_cmd.div_load = 1'b1;
                                n_count        = '0;
                                n_phase        = ioc_pkg::PH_NOISE;
                                n_div_cnt      = '0;
                                n_state        = ST_DIV;
                            end else begin
                                n_count = cnt_inc;
                            end
                        end
                        ioc_pkg::PH_NOISE: begin
                            o_cmd.track = 1'b1;
                            if (phase_end) begin
                                n_count = '0;
                                n_phase = ioc_pkg::PH_RUN;
                            end else begin
                                n_count = cnt_inc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + ioc_pkg::W_DIVC'(1);
                if (r_div_cnt == ioc_pkg::W_DIVC'(ioc_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.div_done = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= ioc_pkg::PH_RUN;
            r_count     <= '0;
            r_calib     <= ioc_pkg::CALIB_RESET;
            r_div_cnt   <= '0;
            r_in_full   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_calib     <= n_calib;
            r_div_cnt   <= n_div_cnt;
            r_in_full   <= n_in_full;
            r_out_valid <= n_out_valid;
        end
    end

    a_div_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_load |=> (r_state == ST_DIV))
        else $error("divide did not start after end of summing");

    a_div_in_noise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_phase == ioc_pkg::PH_NOISE))
        else $error("divide running outside noise phase");

    a_run_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ioc_pkg::PH_RUN) |-> (r_count == '0))
        else $error("sample count not cleared in running phase");

    a_no_proc_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |=> !o_cmd.proc)
        else $error("sample processed while offsets not yet written");

endmodule

>>> design/ioc_datapath.sv
module ioc_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ioc_pkg::t_ctrl_cmd                    i_cmd,
    input  logic                                  i_opcode,
    input  logic signed [ioc_pkg::W_RAW-1:0]      i_raw [ioc_pkg::AXES],
    input  logic [ioc_pkg::W_SEL-1:0]             i_noise_axis,
    output logic                                  o_opcode,
    output logic signed [ioc_pkg::W_DEV-1:0]      o_acc_filt [ioc_pkg::ACC_AXES],
    output logic signed [ioc_pkg::W_DEV-1:0]      o_gyro_corr [ioc_pkg::ACC_AXES],
    output logic [1:0]                            o_phase,
    output logic [ioc_pkg::W_NOISE-1:0]           o_noise_peak
);

    localparam int AX  = ioc_pkg::AXES;
    localparam int ACC = ioc_pkg::ACC_AXES;

    // input buffer
    logic                                 r_opcode;
    logic signed [ioc_pkg::W_RAW-1:0]     r_raw [AX];
    logic [ioc_pkg::W_SEL-1:0]            r_sel;

    // calibration and filter state
    logic signed [ioc_pkg::W_RAW-1:0]     r_offset [AX];
    logic signed [ioc_pkg::W_SUM-1:0]     r_sum    [AX];
    logic [ioc_pkg::W_NOISE-1:0]          r_noise  [AX];
    logic signed [ioc_pkg::W_FILT-1:0]    r_filt   [ACC];

    // offset divider lanes
    logic [ioc_pkg::W_CNT-1:0]            r_rem  [AX];
    logic [ioc_pkg::W_SUM-1:0]            r_quo  [AX];
    logic                                 r_neg  [AX];
    logic [ioc_pkg::W_CNT-1:0]            r_div_n;

    // result register
    logic signed [ioc_pkg::W_DEV-1:0]     r_acc_o  [ACC];
    logic signed [ioc_pkg::W_DEV-1:0]     r_gyro_o [ACC];
    logic [1:0]                           r_phase_o;
    logic [ioc_pkg::W_NOISE-1:0]          r_noise_o;

    logic signed [ioc_pkg::W_DEV-1:0]     dev      [AX];
    logic signed [ioc_pkg::W_SUM-1:0]     sum_base [AX];
    logic signed [ioc_pkg::W_SUM-1:0]     n_sum    [AX];
    logic [ioc_pkg::W_NOISE-1:0]          nz_base  [AX];
    logic [ioc_pkg::W_NOISE-1:0]          n_noise  [AX];
    logic [ioc_pkg::W_DEV-1:0]            mag      [AX];
    logic [ioc_pkg::W_NOISE-1:0]          mag_sat  [AX];
    logic signed [ioc_pkg::W_FSUM-1:0]    fsum     [ACC];
    logic signed [ioc_pkg::W_FSUM-1:0]    fadj     [ACC];
    logic signed [ioc_pkg::W_FSUM-1:0]    fq       [ACC];
    logic signed [ioc_pkg::W_FILT-1:0]    n_filt   [ACC];
    logic [ioc_pkg::W_SUM-1:0]            div_mag  [AX];
    logic [ioc_pkg::W_CNT:0]              trial    [AX];
    logic                                 qbit     [AX];
    logic [ioc_pkg::W_SUM-1:0]            quo_s    [AX];
    logic [ioc_pkg::W_NOISE-1:0]          peak_sel;

    assign o_opcode     = r_opcode;
    assign o_phase      = r_phase_o;
    assign o_noise_peak = r_noise_o;

    always_comb begin
        for (int i = 0; i < AX; i++) begin
            dev[i] = ioc_pkg::W_DEV'(r_raw[i]) - ioc_pkg::W_DEV'(r_offset[i]);
            sum_base[i] = r_opcode ? '0 : r_sum[i];
            nz_base[i]  = r_opcode ? '0 : r_noise[i];
            n_sum[i]    = i_cmd.accum ? sum_base[i] + ioc_pkg::W_SUM'(r_raw[i])
                                      : sum_base[i];
            mag[i]      = dev[i][ioc_pkg::W_DEV-1] ? ioc_pkg::W_DEV'(-dev[i])
                                                   : ioc_pkg::W_DEV'(dev[i]);
            mag_sat[i]  = mag[i][ioc_pkg::W_DEV-1] ? '1 : mag[i][ioc_pkg::W_NOISE-1:0];
            n_noise[i]  = (i_cmd.track && (mag_sat[i] > nz_base[i])) ? mag_sat[i]
                                                                     : nz_base[i];
            div_mag[i]  = n_sum[i][ioc_pkg::W_SUM-1] ? ioc_pkg::W_SUM'(-n_sum[i])
                                                     : ioc_pkg::W_SUM'(n_sum[i]);
            trial[i]    = {r_rem[i], r_quo[i][ioc_pkg::W_SUM-1]};
            qbit[i]     = (trial[i] >= {1'b0, r_div_n});
            quo_s[i]    = r_neg[i] ? ioc_pkg::W_SUM'(-r_quo[i]) : r_quo[i];
        end
        // acc = trunc((x + 3*acc) / 4), rounding toward zero
        for (int i = 0; i < ACC; i++) begin
            fsum[i]   = ioc_pkg::W_FSUM'(dev[i]) + (ioc_pkg::W_FSUM'(r_filt[i]) <<< 1)
                      + ioc_pkg::W_FSUM'(r_filt[i]);
            fadj[i]   = fsum[i] + (fsum[i][ioc_pkg::W_FSUM-1] ? ioc_pkg::W_FSUM'(3)
                                                              : ioc_pkg::W_FSUM'(0));
            fq[i]     = fadj[i] >>> 2;
            n_filt[i] = fq[i][ioc_pkg::W_FILT-1:0];
        end
        peak_sel = (r_sel < ioc_pkg::W_SEL'(AX)) ? n_noise[r_sel] : '0;
    end

    // state with a defined reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AX; i++) begin
                r_offset[i] <= '0;
                r_sum[i]    <= '0;
                r_noise[i]  <= '0;
            end
            for (int i = 0; i < ACC; i++) begin
                r_filt[i] <= '0;
            end
        end else begin
            if (i_cmd.proc) begin
                for (int i = 0; i < AX; i++) begin
                    r_sum[i]   <= n_sum[i];
                    r_noise[i] <= n_noise[i];
                end
                for (int i = 0; i < ACC; i++) begin
                    r_filt[i] <= n_filt[i];
                end
            end
            if (i_cmd.div_done) begin
                for (int i = 0; i < AX; i++) begin
                    r_offset[i] <= quo_s[i][ioc_pkg::W_RAW-1:0];
                end
            end
        end
    end

    // payload: input buffer, divider, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode <= i_opcode;
            r_sel    <= i_noise_axis;
            for (int i = 0; i < AX; i++) begin
                r_raw[i] <= i_raw[i];
            end
        end
        if (i_cmd.div_load) begin
            r_div_n <= i_cmd.div_n;
            for (int i = 0; i < AX; i++) begin
                r_rem[i] <= '0;
                r_quo[i] <= div_mag[i];
                r_neg[i] <= n_sum[i][ioc_pkg::W_SUM-1];
            end
        end else if (i_cmd.div_step) begin
            for (int i = 0; i < AX; i++) begin
                r_rem[i] <= qbit[i] ? ioc_pkg::W_CNT'(trial[i] - {1'b0, r_div_n})
                                    : trial[i][ioc_pkg::W_CNT-1:0];
                r_quo[i] <= {r_quo[i][ioc_pkg::W_SUM-2:0], qbit[i]};
            end
        end
        if (i_cmd.proc) begin
            for (int i = 0; i < ACC; i++) begin
                r_acc_o[i]  <= n_filt[i][ioc_pkg::W_DEV-1:0];
                r_gyro_o[i] <= dev[ACC + i];
            end
            r_phase_o <= i_cmd.ph;
            r_noise_o <= peak_sel;
        end
    end

    always_comb begin
        for (int i = 0; i < ACC; i++) begin
            o_acc_filt[i]  = r_acc_o[i];
            o_gyro_corr[i] = r_gyro_o[i];
        end
    end

endmodule

>>> design/imu_offset_calibration_filter.sv
// Path: an input is held in the input buffer, then its result in the result register; a busy
//   output or a running divide keeps the input in the buffer until it can be processed.
// Flow: a new input is taken only once the buffered one is processed; the sample that closes
//   the summing phase holds the controller in the divider while six radix-2 divider lanes form
//   the offsets (26 quotient bits, then a write). One further input is buffered meanwhile.
// Reset: i_rst_n synchronous, active low; running phase, offsets, sums, peaks and
//   filters cleared, sample count register set to 100.
module imu_offset_calibration_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ioc_in_if.sink                        i_in,
    ioc_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [ioc_pkg::W_CNT-1:0]     i_cfg_wdata
);

    ioc_pkg::t_ctrl_cmd                   cmd;
    logic                                 buf_opcode;
    logic signed [ioc_pkg::W_RAW-1:0]     raw       [ioc_pkg::AXES];
    logic signed [ioc_pkg::W_DEV-1:0]     acc_filt  [ioc_pkg::ACC_AXES];
    logic signed [ioc_pkg::W_DEV-1:0]     gyro_corr [ioc_pkg::ACC_AXES];

    // axis order: accel x, y, z, then gyro x, y, z
    assign raw[0] = i_in.acc_x_raw;
    assign raw[1] = i_in.acc_y_raw;
    assign raw[2] = i_in.acc_z_raw;
    assign raw[3] = i_in.gyro_x_raw;
    assign raw[4] = i_in.gyro_y_raw;
    assign raw[5] = i_in.gyro_z_raw;

    // Controller: handshake, phase and sample count, divider sequencing.
    // A restart sample is decided from the buffered opcode at processing time.
    ioc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_opcode    (buf_opcode),
        .o_cmd       (cmd)
    );

    // Datapath: offset subtract, alpha = 1/4 low-pass, sums, peak tracking,
    // and the divider lanes that turn sums into offsets.
    ioc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_in.opcode),
        .i_raw        (raw),
        .i_noise_axis (i_in.noise_axis),
        .o_opcode     (buf_opcode),
        .o_acc_filt   (acc_filt),
        .o_gyro_corr  (gyro_corr),
        .o_phase      (o_out.phase),
        .o_noise_peak (o_out.noise_peak)
    );

    assign o_out.acc_x_filt  = acc_filt[0];
    assign o_out.acc_y_filt  = acc_filt[1];
    assign o_out.acc_z_filt  = acc_filt[2];
    assign o_out.gyro_x_corr = gyro_corr[0];
    assign o_out.gyro_y_corr = gyro_corr[1];
    assign o_out.gyro_z_corr = gyro_corr[2];

endmodule
